[design/sss_pkg.sv]
package sss_pkg;

  localparam int WORD_W  = 32;
  localparam int FUNC_W  = 2;
  localparam int COUNT_W = 7;

  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;

  typedef logic [WORD_W-1:0] word_t;

  // broadcast to every cell
  typedef struct packed {
    logic  ins_en;
    logic  rem_en;
    word_t value;
  } cell_ctrl_t;

  // what a cell hands to its right neighbor
  typedef struct packed {
    word_t entry;
    logic  above;
  } cell_link_t;

endpackage

[design/sss_if.sv]
interface sss_req_if;
  import sss_pkg::*;
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic signed [WORD_W-1:0] value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

interface sss_rsp_if;
  import sss_pkg::*;
  logic               valid;
  logic               ready;
  logic               was_member;
  logic               changed;
  logic               full_reject;
  logic [COUNT_W-1:0] element_count;

  modport source (output valid, output was_member, output changed, output full_reject,
                  output element_count, input ready);
  modport sink   (input valid, input was_member, input changed, input full_reject,
                  input element_count, output ready);
endinterface

[design/sss_cell.sv]
module sss_cell (
  input  logic                clk,
  input  sss_pkg::cell_ctrl_t ctrl,
  input  logic                valid,
  input  sss_pkg::cell_link_t left,
  input  sss_pkg::word_t      right_entry,
  output sss_pkg::cell_link_t link,
  output logic                eq
);
  import sss_pkg::*;

  word_t entry;
  word_t entry_next;
  logic  above;

  // at or past the insertion point: empty, or entry not below the key
  assign above = !valid || ($signed(entry) >= $signed(ctrl.value));
  assign eq    = valid && (entry == ctrl.value);

  assign link.entry = entry;
  assign link.above = above;

  always_comb begin
    entry_next = entry;
    if (ctrl.ins_en) begin
      if (left.above) begin
        entry_next = left.entry;
      end else if (above) begin
        entry_next = ctrl.value;
      end
    end else if (ctrl.rem_en) begin
      if (above) begin
        entry_next = right_entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

[design/sorted_set_store_core.sv]
// Sorted set of up to CAPACITY distinct signed 32-bit values, one cell per
// entry. Each beat on req inserts (func 0), removes (func 1) or looks up
// (func 2, and 3) one value; exactly one rsp beat follows for each. Every
// cell compares its entry with the value and shifts toward its neighbor in
// the same cycle, so items run back to back; the result sits in an output
// register and req stays ready while that register is empty or being taken.
// element_count is the count modulo 128.
module sorted_set_store_core #(
  parameter int CAPACITY = 64
) (
  input  logic          clk,
  input  logic          rst,
  sss_req_if.sink       req,
  sss_rsp_if.source     rsp
);
  import sss_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]       count;
  logic [CW-1:0]       count_next;
  cell_ctrl_t          ctrl;
  cell_link_t          links [CAPACITY];
  logic [CAPACITY-1:0] eq_vec;
  logic [CAPACITY-1:0] valid_vec;
  logic                accept;
  logic                found;
  logic                is_ins;
  logic                is_rem;
  logic                has_room;

  assign req.ready = !rsp.valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  assign found    = |eq_vec;
  assign is_ins   = (req.func == FUNC_INSERT);
  assign is_rem   = (req.func == FUNC_REMOVE);
  assign has_room = (count < CW'(CAPACITY));

  assign ctrl.value  = word_t'(req.value);
  assign ctrl.ins_en = accept && is_ins && !found && has_room;
  assign ctrl.rem_en = accept && is_rem && found;

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      cell_link_t left_link;
      word_t      right_entry;

      assign valid_vec[i] = (count > CW'(i));

      if (i == 0) begin : g_first
        assign left_link = '{entry: '0, above: 1'b0};
      end else begin : g_mid
        assign left_link = links[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
        assign right_entry = '0;
      end else begin : g_inner
        assign right_entry = links[i+1].entry;
      end

      sss_cell u_cell (
        .clk         (clk),
        .ctrl        (ctrl),
        .valid       (valid_vec[i]),
        .left        (left_link),
        .right_entry (right_entry),
        .link        (links[i]),
        .eq          (eq_vec[i])
      );
    end
  endgenerate

  always_comb begin
    count_next = count;
    if (ctrl.ins_en) begin
      count_next = count + CW'(1);
    end else if (ctrl.rem_en) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.was_member    <= found;
      rsp.changed       <= ctrl.ins_en || ctrl.rem_en;
      rsp.full_reject   <= is_ins && !found && !has_room;
      rsp.element_count <= COUNT_W'({{COUNT_W{1'b0}}, count_next});
    end
  end

endmodule
